// ===== design/circular_deque_assert.svh =====
// Assertion macros used by the design file circular_deque.sv.
// Each macro takes a label, an antecedent and a consequent.
// The clock is clk and the checks are switched off while arst_n is low.
`ifndef CIRCULAR_DEQUE_ASSERT_SVH
`define CIRCULAR_DEQUE_ASSERT_SVH

`ifndef SYNTH
`define CDQ_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("circular_deque check failed");
`define CDQ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("circular_deque check failed");
`else
`define CDQ_ASSERT_SAME(label, ante, cons)
`define CDQ_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== design/cdq_pkg.sv =====
package cdq_pkg;

	localparam int DATA_W  = 32;
	localparam int FUNC_W  = 3;
	localparam int CAP_W   = 5;
	// Largest capacity the register can express.
	localparam int MAX_CAP = 31;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
	localparam logic signed [DATA_W-1:0] EMPTY_MARK = 32'shFFFF_FFFF;

	// Operation codes; any other code behaves as a peek.
	localparam logic [FUNC_W-1:0] FN_INS_FRONT = 3'd0;
	localparam logic [FUNC_W-1:0] FN_INS_REAR  = 3'd1;
	localparam logic [FUNC_W-1:0] FN_DEL_FRONT = 3'd2;
	localparam logic [FUNC_W-1:0] FN_DEL_REAR  = 3'd3;
	localparam logic [FUNC_W-1:0] FN_PEEK      = 3'd4;

	typedef struct packed {
		logic [FUNC_W-1:0]        func;
		logic signed [DATA_W-1:0] item_value;
	} req_t;

	typedef struct packed {
		logic                     ok;
		logic signed [DATA_W-1:0] front_value;
		logic signed [DATA_W-1:0] rear_value;
		logic                     is_empty;
		logic                     is_full;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_READ,
		ST_RESP
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic cfg_wr;
		logic load;
		logic exec;
		logic read;
	} cmd_t;

endpackage

// ===== design/cdq_ctrl.sv =====
module cdq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	output cdq_pkg::cmd_t cmd
);
	import cdq_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: state_d = ST_READ;
			ST_READ: state_d = ST_RESP;
			ST_RESP: begin
				if (!rsp_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req_stall  = 1'b1;
		rsp_valid  = 1'b0;
		cfg_ready  = 1'b0;
		cmd        = '0;
		case (state_q)
			ST_IDLE: begin
				req_stall  = 1'b0;
				cfg_ready  = 1'b1;
				cmd.load   = req_valid;
				cmd.cfg_wr = cfg_valid;
			end
			ST_EXEC: cmd.exec = 1'b1;
			ST_READ: cmd.read = 1'b1;
			ST_RESP: rsp_valid = 1'b1;
			default: req_stall = 1'b1;
		endcase
	end

endmodule

// ===== design/cdq_datapath.sv =====
module cdq_datapath #(
	parameter int DEPTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cdq_pkg::cmd_t                cmd,
	input  cdq_pkg::req_t                req,
	input  logic [cdq_pkg::CAP_W-1:0]    cfg_data,
	output cdq_pkg::rsp_t                rsp
);
	import cdq_pkg::*;

	// Only as many entries as the capacity register can reach are stored.
	localparam int USE_DEPTH = (DEPTH < MAX_CAP) ? DEPTH : MAX_CAP;
	localparam int PW        = (USE_DEPTH > 1) ? $clog2(USE_DEPTH) : 1;
	localparam logic [CAP_W-1:0] USE_CAP  = CAP_W'(USE_DEPTH);
	localparam logic [CAP_W-1:0] CAP_INIT = (USE_CAP < CAP_RESET) ? USE_CAP : CAP_RESET;

	logic [DATA_W-1:0] mem [USE_DEPTH];

	logic [FUNC_W-1:0]        func_q;
	logic signed [DATA_W-1:0] val_q;
	logic [CAP_W-1:0]         cap_q;
	logic [PW-1:0]            head_q;
	logic [PW-1:0]            tail_q;
	logic [CAP_W-1:0]         cnt_q;
	logic                     ok_q;
	logic [DATA_W-1:0]        front_q;
	logic [DATA_W-1:0]        rear_q;

	logic [CAP_W-1:0] cap_m1;
	logic [CAP_W-1:0] cap_new;
	logic [PW-1:0]    head_next;
	logic [PW-1:0]    head_prev;
	logic [PW-1:0]    tail_next;
	logic [PW-1:0]    tail_prev;
	logic [PW-1:0]    head_d;
	logic [PW-1:0]    tail_d;
	logic [CAP_W-1:0] cnt_d;
	logic [PW-1:0]    wr_addr;
	logic             wr_en;
	logic             ok_d;
	logic             full;
	logic             empty;

	assign cap_m1 = cap_q - 5'd1;

	// Pointer steps wrap at the capacity rather than at the store depth.
	assign head_next = (CAP_W'(head_q) == cap_m1) ? '0 : head_q + 1'b1;
	assign tail_next = (CAP_W'(tail_q) == cap_m1) ? '0 : tail_q + 1'b1;
	assign head_prev = (head_q == '0) ? PW'(cap_m1) : head_q - 1'b1;
	assign tail_prev = (tail_q == '0) ? PW'(cap_m1) : tail_q - 1'b1;

	assign full  = cnt_q >= cap_q;
	assign empty = cnt_q == '0;

	// A zero capacity acts as one; anything beyond the store acts as its size.
	always_comb begin
		cap_new = cfg_data;
		if (cfg_data == '0) begin
			cap_new = 5'd1;
		end else if (cfg_data > USE_CAP) begin
			cap_new = USE_CAP;
		end
	end

	always_comb begin
		head_d  = head_q;
		tail_d  = tail_q;
		cnt_d   = cnt_q;
		ok_d    = 1'b1;
		wr_en   = 1'b0;
		wr_addr = head_q;
		case (func_q)
			FN_INS_FRONT: begin
				if (full) begin
					ok_d = 1'b0;
				end else begin
					// An insert into an empty queue lands where both pointers sit.
					if (!empty) begin
						head_d = head_prev;
					end
					wr_en   = 1'b1;
					wr_addr = empty ? head_q : head_prev;
					cnt_d   = cnt_q + 5'd1;
				end
			end
			FN_INS_REAR: begin
				if (full) begin
					ok_d = 1'b0;
				end else begin
					if (!empty) begin
						tail_d = tail_next;
					end
					wr_en   = 1'b1;
					wr_addr = empty ? tail_q : tail_next;
					cnt_d   = cnt_q + 5'd1;
				end
			end
			FN_DEL_FRONT: begin
				if (empty) begin
					ok_d = 1'b0;
				end else begin
					// Removing the last entry leaves both pointers in place.
					if (cnt_q > 5'd1) begin
						head_d = head_next;
					end
					cnt_d = cnt_q - 5'd1;
				end
			end
			FN_DEL_REAR: begin
				if (empty) begin
					ok_d = 1'b0;
				end else begin
					if (cnt_q > 5'd1) begin
						tail_d = tail_prev;
					end
					cnt_d = cnt_q - 5'd1;
				end
			end
			default: ok_d = 1'b1;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= req.func;
			val_q  <= req.item_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q  <= CAP_INIT;
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
			ok_q   <= 1'b0;
		end else if (cmd.cfg_wr) begin
			cap_q  <= cap_new;
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
		end else if (cmd.exec) begin
			head_q <= head_d;
			tail_q <= tail_d;
			cnt_q  <= cnt_d;
			ok_q   <= ok_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && wr_en) begin
			mem[wr_addr] <= val_q;
		end
		if (cmd.read) begin
			front_q <= mem[head_q];
			rear_q  <= mem[tail_q];
		end
	end

	always_comb begin
		rsp.ok          = ok_q;
		rsp.is_empty    = empty;
		rsp.is_full     = full;
		rsp.front_value = empty ? EMPTY_MARK : front_q;
		rsp.rear_value  = empty ? EMPTY_MARK : rear_q;
	end

endmodule

// ===== design/circular_deque.sv =====
// A request accepted in the idle state passes through the update and store-read
// states before its result is offered in the result-hold state. A new request is
// accepted only once the result has been taken; the controller steps through
// accept, update and write, store read, and result hold.
// Reset (arst_n, asynchronous, active low) empties the queue and sets the capacity
// to 16, or to DEPTH if that is smaller; the store contents are not cleared.
`include "circular_deque_assert.svh"

module circular_deque #(
	parameter int DEPTH = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_stall,
	input  cdq_pkg::req_t             req,
	output logic                      rsp_valid,
	input  logic                      rsp_stall,
	output cdq_pkg::rsp_t             rsp,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [cdq_pkg::CAP_W-1:0] cfg_data
);
	import cdq_pkg::*;

	// The controller sequences each request and issues commands to the
	// datapath, which owns the pointers, the entry count, the capacity
	// register and the ring store.
	cmd_t cmd;

	// The controller accepts a request only when idle, so one request is in
	// flight at a time. Capacity writes are also taken only while idle; a
	// write clears both pointers and the count, which empties the queue.
	cdq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cmd       (cmd)
	);

	// The datapath latches the request, applies the operation to the pointers
	// and count (writing the store on an insert), then reads the front and
	// rear entries at both pointers into registers. The result is built from
	// those registers and holds steady while the output stalls.
	cdq_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.req      (req),
		.cfg_data (cfg_data),
		.rsp      (rsp)
	);

	// While a result is offered, no new request may enter.
	`CDQ_ASSERT_SAME(a_one_in_flight, rsp_valid, req_stall)
	// An accepted request never produces its result in the very next cycle.
	`CDQ_ASSERT_NEXT(a_no_early_rsp, req_valid && !req_stall, req_stall && !rsp_valid)
	// An empty queue reports the empty mark on both ends.
	`CDQ_ASSERT_SAME(a_empty_mark, rsp_valid && rsp.is_empty,
		rsp.front_value == EMPTY_MARK && rsp.rear_value == EMPTY_MARK)
	// The capacity is at least one, so a queue is never both empty and full.
	`CDQ_ASSERT_SAME(a_empty_full, rsp_valid, !(rsp.is_empty && rsp.is_full))

endmodule
